// File: hw/rtl/jcs_pkg.sv
// ----------------------------------------------------------------------------
// jcs_pkg
// Types and character constants shared by the comment stripper modules.
// ----------------------------------------------------------------------------
package jcs_pkg;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_final;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       end_of_text;
  } out_word_t;

  // One classified input byte: one or two results to emit.
  typedef struct packed {
    logic       two;
    logic [7:0] b0;
    logic       v0;
    logic [7:0] b1;
    logic       fin;
  } action_t;

  typedef struct packed {
    logic half;
    logic load;
  } bk_stat_t;

endpackage

// File: hw/rtl/jcs_front.sv
// ----------------------------------------------------------------------------
// jcs_front
// Lexer: tracks comment/string mode and turns input words that emit bytes into actions.
// ----------------------------------------------------------------------------
module jcs_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_wdata,
  input  logic             accept,
  input  jcs_pkg::in_word_t in_word,
  output logic             act_push,
  output jcs_pkg::action_t act
);

  localparam logic [2:0] MODE_NORMAL = 3'd0;
  localparam logic [2:0] MODE_SLASH  = 3'd1;
  localparam logic [2:0] MODE_LINE   = 3'd2;
  localparam logic [2:0] MODE_BLOCK  = 3'd3;
  localparam logic [2:0] MODE_BSTAR  = 3'd4;
  localparam logic [2:0] MODE_STRING = 3'd5;

  logic [2:0] mode_r, mode_nxt;
  logic       en_r, en_nxt;
  logic [1:0] n;
  logic [7:0] r0, r1, c;
  logic       v0;

  assign c = in_word.in_byte;

  always_comb begin
    n        = 2'd0;
    r0       = 8'h00;
    r1       = 8'h00;
    v0       = 1'b1;
    mode_nxt = mode_r;
    if (!en_r) begin
      if (mode_r == MODE_SLASH) begin
        n  = 2'd2;
        r0 = jcs_pkg::CH_SLASH;
        r1 = c;
      end else begin
        n  = 2'd1;
        r0 = c;
      end
      mode_nxt = MODE_NORMAL;
    end else begin
      case (mode_r)
        MODE_SLASH: begin
          if (c == jcs_pkg::CH_SLASH) begin
            mode_nxt = MODE_LINE;
          end else if (c == jcs_pkg::CH_STAR) begin
            mode_nxt = MODE_BLOCK;
          end else begin
            n        = 2'd2;
            r0       = jcs_pkg::CH_SLASH;
            r1       = c;
            mode_nxt = (c == jcs_pkg::CH_QUOTE) ? MODE_STRING : MODE_NORMAL;
          end
        end
        MODE_LINE: begin
          if (c == jcs_pkg::CH_NL) begin
            n        = 2'd1;
            r0       = c;
            mode_nxt = MODE_NORMAL;
          end
        end
        MODE_BLOCK: begin
          if (c == jcs_pkg::CH_STAR) begin
            mode_nxt = MODE_BSTAR;
          end
        end
        MODE_BSTAR: begin
          if (c == jcs_pkg::CH_SLASH) begin
            mode_nxt = MODE_NORMAL;
          end else if (c != jcs_pkg::CH_STAR) begin
            mode_nxt = MODE_BLOCK;
          end
        end
        MODE_STRING: begin
          n  = 2'd1;
          r0 = c;
          if (c == jcs_pkg::CH_QUOTE) begin
            mode_nxt = MODE_NORMAL;
          end
        end
        default: begin
          if (c == jcs_pkg::CH_SLASH) begin
            mode_nxt = MODE_SLASH;
          end else begin
            n        = 2'd1;
            r0       = c;
            mode_nxt = (c == jcs_pkg::CH_QUOTE) ? MODE_STRING : MODE_NORMAL;
          end
        end
      endcase
    end
    if (in_word.is_final) begin
      if (mode_nxt == MODE_SLASH) begin
        n  = 2'd1;
        r0 = jcs_pkg::CH_SLASH;
      end
      if (n == 2'd0) begin
        n  = 2'd1;
        r0 = 8'h00;
        v0 = 1'b0;
      end
      mode_nxt = MODE_NORMAL;
    end
  end

  assign act_push = accept && (n != 2'd0);
  assign act.two  = (n == 2'd2);
  assign act.b0   = r0;
  assign act.v0   = v0;
  assign act.b1   = r1;
  assign act.fin  = in_word.is_final;

  assign en_nxt = cfg_we ? cfg_wdata : en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
      en_r   <= 1'b1;
    end else begin
      en_r <= en_nxt;
      if (accept) begin
        mode_r <= mode_nxt;
      end
    end
  end

endmodule

// File: hw/rtl/jcs_queue.sv
// ----------------------------------------------------------------------------
// jcs_queue
// Small register queue of actions between the lexer and the emitter.
// ----------------------------------------------------------------------------
module jcs_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  jcs_pkg::action_t wdata,
  output logic             full,
  input  logic             pop,
  output jcs_pkg::action_t rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  jcs_pkg::action_t mem_r [DEPTH];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == LAST) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == LAST) ? '0 : rp_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
  end

endmodule

// File: hw/rtl/jcs_back.sv
// ----------------------------------------------------------------------------
// jcs_back
// Emitter: expands each action into one or two output words.
// ----------------------------------------------------------------------------
module jcs_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  jcs_pkg::action_t   q_data,
  output logic               q_pop,
  output logic               empty,
  input  logic               pop,
  output jcs_pkg::out_word_t out_word,
  output jcs_pkg::bk_stat_t  stat
);

  jcs_pkg::out_word_t word_r, word_nxt;
  logic vld_r, vld_nxt, half_r, half_nxt, load;

  assign load  = (!vld_r || pop) && !q_empty;
  assign q_pop = load && (half_r || !q_data.two);

  always_comb begin
    word_nxt = word_r;
    if (load) begin
      if (!half_r) begin
        word_nxt.out_byte    = q_data.b0;
        word_nxt.byte_valid  = q_data.v0;
        word_nxt.run_last    = !q_data.two;
        word_nxt.end_of_text = q_data.fin && !q_data.two;
      end else begin
        word_nxt.out_byte    = q_data.b1;
        word_nxt.byte_valid  = 1'b1;
        word_nxt.run_last    = 1'b1;
        word_nxt.end_of_text = q_data.fin;
      end
    end
  end

  assign half_nxt = load ? (!half_r && q_data.two) : half_r;
  assign vld_nxt  = load ? 1'b1 : (pop ? 1'b0 : vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      half_r <= 1'b0;
    end else begin
      vld_r  <= vld_nxt;
      half_r <= half_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign empty     = !vld_r;
  assign out_word  = word_r;
  assign stat.half = half_r;
  assign stat.load = load;

endmodule

// File: hw/rtl/json_comment_stripper.sv
// Streams text one byte per word and removes line and block comments while
// quoted strings pass untouched. An input word is taken every cycle while
// the internal action queue (QDEPTH entries) has room; the output side emits
// one word per cycle from its output register while pop is held, so a byte
// that releases a held slash yields two output words and sustained rate is
// one byte per cycle otherwise. The first result of a word passes through the
// action queue and then the output register before it reaches the ports.
// cfg_wdata drives the strip enable: low passes every byte as is.
// ----------------------------------------------------------------------------
// json_comment_stripper
// Top level: lexer front end, action queue and result emitter.
// ----------------------------------------------------------------------------
module json_comment_stripper #(
  parameter int QDEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  logic               push,
  input  jcs_pkg::in_word_t  in_word,
  output logic               full,
  input  logic               pop,
  output jcs_pkg::out_word_t out_word,
  output logic               empty
);

  jcs_pkg::action_t  act, q_data;
  jcs_pkg::bk_stat_t stat;
  logic act_push, q_empty, q_pop, accept;

  assign accept = push && !full;

  jcs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .accept   (accept),
    .in_word  (in_word),
    .act_push (act_push),
    .act      (act)
  );

  jcs_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (act_push),
    .wdata(act),
    .full (full),
    .pop  (q_pop),
    .rdata(q_data),
    .empty(q_empty)
  );

  jcs_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .out_word(out_word),
    .stat    (stat)
  );

  // end of text always closes the run of its input byte
  a_eot_last: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_word.end_of_text |-> out_word.run_last)
    else $error("end_of_text without run_last");

  // end-only marker is the final word and carries no byte
  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !out_word.byte_valid |->
      out_word.end_of_text && (out_word.out_byte == 8'h00))
    else $error("malformed end-only word");

  // second half of a two-word action keeps its queue entry
  a_half: assert property (@(posedge clk) disable iff (!rst_n)
    stat.half |-> !q_empty)
    else $error("second word pending with empty queue");

  // a pending second word is emitted before the entry leaves
  a_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && q_data.two |-> stat.half && stat.load)
    else $error("two-word action popped early");

endmodule
